/* rtl/raster_rle_byte_decoder_top_defines.svh */
// ----------------------------------------------------------------------------
// Raster RLE byte decoder - assertion macros
// Shared property macros for the decoder's checker.
// ----------------------------------------------------------------------------
`ifndef RASTER_RLE_BYTE_DECODER_TOP_DEFINES_SVH
`define RASTER_RLE_BYTE_DECODER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define RRLE_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset.
`define RRLE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/rrle_pkg.sv */
// ----------------------------------------------------------------------------
// rrle_pkg
// Types and constants shared by the raster RLE byte decoder modules.
// ----------------------------------------------------------------------------
`default_nettype none

package rrle_pkg;

	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] REG_TOTAL_BYTES  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_INPUT_BUDGET = 1'b1;

	localparam logic [31:0] TOTAL_RESET  = 32'd1;
	localparam logic [31:0] BUDGET_RESET = 32'd0;

	localparam logic [7:0] ESCAPE_CODE = 8'd128;

	// Configuration seen by the decode core
	typedef struct packed {
		logic [31:0] total_bytes;
		logic [31:0] eff_budget;
		logic        restart;
	} rrle_cfg_t;

	// One decoded run
	typedef struct packed {
		logic [7:0] value;
		logic [8:0] length;
		logic       last;
	} rrle_run_t;

endpackage

`default_nettype wire

/* rtl/rrle_in_reg.sv */
// ----------------------------------------------------------------------------
// rrle_in_reg
// Input register: captures one code byte and holds it until the core takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module rrle_in_reg (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] code_byte,
	input  wire logic       advance,
	output logic            valid_s1,
	output logic [7:0]      byte_s1
);
	import rrle_pkg::*;

	// free when empty or when the held item moves on this cycle
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= code_byte;
		end
	end

endmodule

`default_nettype wire

/* rtl/rrle_cfg_regs.sv */
// ----------------------------------------------------------------------------
// rrle_cfg_regs
// Configuration registers and the restart pulse that follows every write.
// ----------------------------------------------------------------------------
`default_nettype none

module rrle_cfg_regs (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [rrle_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  wire logic [31:0]                   cfg_wdata,
	output rrle_pkg::rrle_cfg_t                cfg
);
	import rrle_pkg::*;

	logic [31:0] total_q;
	logic [31:0] budget_q;
	logic        restart_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q   <= TOTAL_RESET;
			budget_q  <= BUDGET_RESET;
			restart_q <= 1'b0;
		end else begin
			restart_q <= cfg_we;
			if (cfg_we) begin
				unique case (cfg_idx)
					REG_TOTAL_BYTES:  total_q  <= cfg_wdata;
					REG_INPUT_BUDGET: budget_q <= cfg_wdata;
					default: ;
				endcase
			end
		end
	end

	always_comb begin
		cfg.total_bytes = total_q;
		// zero budget falls back to the decoded total
		cfg.eff_budget  = (budget_q != 32'd0) ? budget_q : total_q;
		cfg.restart     = restart_q;
	end

endmodule

`default_nettype wire

/* rtl/rrle_core.sv */
// ----------------------------------------------------------------------------
// rrle_core
// Escape-phase tracking, run clamping, counters and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rrle_core (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire rrle_pkg::rrle_cfg_t cfg,
	input  wire logic                valid_s1,
	input  wire logic [7:0]          byte_s1,
	output logic                     advance,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output rrle_pkg::rrle_run_t      run
);
	import rrle_pkg::*;

	typedef enum logic [1:0] {
		PH_PLAIN = 2'd0,
		PH_COUNT = 2'd1,
		PH_VALUE = 2'd2
	} phase_t;

	phase_t      phase_q;
	logic [7:0]  pend_q;
	logic [31:0] left_out_q;
	logic [31:0] left_in_q;
	logic        finished_q;
	logic        out_valid_q;
	rrle_run_t   run_q;

	phase_t      nxt_phase;
	logic [7:0]  nxt_pend;
	logic [31:0] nxt_in;
	logic [31:0] nxt_out;
	logic        nxt_finish;
	logic        emit;
	logic [7:0]  emit_value;
	logic [8:0]  emit_len;
	logic [31:0] in_dec;
	logic [31:0] out_lim;
	logic [7:0]  extra;
	logic        take;

	assign advance = valid_s1 && (!out_valid_q || out_ready);
	assign take    = advance && !finished_q;

	assign in_dec  = (left_in_q != 32'd0) ? (left_in_q - 32'd1) : 32'd0;
	assign out_lim = left_out_q - 32'd1;
	// clamp the escape count to what is still expected
	assign extra   = ({24'd0, pend_q} > out_lim) ? out_lim[7:0] : pend_q;

	always_comb begin
		nxt_phase  = phase_q;
		nxt_pend   = pend_q;
		nxt_in     = left_in_q;
		nxt_finish = 1'b0;
		emit       = 1'b0;
		emit_value = byte_s1;
		emit_len   = 9'd1;
		unique case (phase_q)
			PH_COUNT: begin
				nxt_in = in_dec;
				if (byte_s1 == 8'd0) begin
					nxt_phase  = PH_PLAIN;
					emit       = 1'b1;
					emit_value = ESCAPE_CODE;
				end else begin
					nxt_pend  = byte_s1;
					nxt_phase = PH_VALUE;
				end
			end
			PH_VALUE: begin
				nxt_in    = in_dec;
				nxt_phase = PH_PLAIN;
				emit      = 1'b1;
				emit_len  = {1'b0, extra} + 9'd1;
			end
			default: begin
				nxt_phase = PH_PLAIN;
				if (left_out_q == 32'd0 || left_in_q == 32'd0) begin
					nxt_finish = 1'b1;
				end else begin
					nxt_in = in_dec;
					if (byte_s1 == ESCAPE_CODE) begin
						nxt_phase = PH_COUNT;
					end else begin
						emit = 1'b1;
					end
				end
			end
		endcase
		nxt_out = left_out_q - {23'd0, emit_len};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_PLAIN;
			pend_q      <= 8'd0;
			left_out_q  <= TOTAL_RESET;
			left_in_q   <= TOTAL_RESET;
			finished_q  <= 1'b0;
			out_valid_q <= 1'b0;
			run_q       <= '0;
		end else if (cfg.restart) begin
			phase_q    <= PH_PLAIN;
			pend_q     <= 8'd0;
			left_out_q <= cfg.total_bytes;
			left_in_q  <= cfg.eff_budget;
			finished_q <= 1'b0;
		end else begin
			if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (take) begin
				phase_q   <= nxt_phase;
				pend_q    <= nxt_pend;
				left_in_q <= nxt_in;
				if (nxt_finish) begin
					finished_q <= 1'b1;
				end
				if (emit) begin
					left_out_q   <= nxt_out;
					out_valid_q  <= 1'b1;
					run_q.value  <= emit_value;
					run_q.length <= emit_len;
					run_q.last   <= (nxt_out == 32'd0) || (nxt_in == 32'd0);
					if ((nxt_out == 32'd0) || (nxt_in == 32'd0)) begin
						finished_q <= 1'b1;
					end
				end
			end
		end
	end

	assign out_valid = out_valid_q;
	assign run       = run_q;

endmodule

`default_nettype wire

/* rtl/raster_rle_byte_decoder_top.sv */
// ----------------------------------------------------------------------------
// raster_rle_byte_decoder_top
// Byte-encoded raster run decoder: one compressed byte in, at most one run out.
// ----------------------------------------------------------------------------
// Takes one code byte per cycle. Each byte is registered, then decoded against
// the escape phase and the two down-counters once the result register is empty
// or being read, and any run lands in the result register. Input ready drops
// only while the result register holds a run that the sink has not taken. A
// configuration write restarts decoding through a registered restart pulse;
// write only while no item is in flight. After the run flagged final_run,
// further bytes are accepted and dropped until the next write.
`default_nettype none

module raster_rle_byte_decoder_top (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [7:0]                    code_byte,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [7:0]                         run_value,
	output logic [8:0]                         run_length,
	output logic                               final_run,
	input  wire logic                          cfg_we,
	input  wire logic [rrle_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  wire logic [31:0]                   cfg_wdata
);
	import rrle_pkg::*;

	rrle_cfg_t  cfg;
	rrle_run_t  run;
	logic       advance;
	logic       valid_s1;
	logic [7:0] byte_s1;

	rrle_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	rrle_in_reg u_in (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.code_byte (code_byte),
		.advance   (advance),
		.valid_s1  (valid_s1),
		.byte_s1   (byte_s1)
	);

	rrle_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.valid_s1  (valid_s1),
		.byte_s1   (byte_s1),
		.advance   (advance),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.run       (run)
	);

	assign run_value  = run.value;
	assign run_length = run.length;
	assign final_run  = run.last;

endmodule

`default_nettype wire

/* rtl/rrle_checker.sv */
// ----------------------------------------------------------------------------
// rrle_checker
// Port-level checks for the raster RLE byte decoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "raster_rle_byte_decoder_top_defines.svh"

module rrle_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [7:0] run_value,
	input wire logic [8:0] run_length,
	input wire logic       final_run
);
	import rrle_pkg::*;

	// a stalled run holds
	`RRLE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(run_value) && $stable(run_length) && $stable(final_run), "stalled run changed")

	`RRLE_ASSERT_NOW(a_len_range, out_valid, run_length != 9'd0 && run_length <= 9'd256, "run length out of range")

	// nothing follows the final run
	`RRLE_ASSERT_NEXT(a_final_quiet, out_valid && out_ready && final_run, !out_valid, "run after final run")

endmodule

bind raster_rle_byte_decoder_top rrle_checker u_rrle_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.run_value  (run_value),
	.run_length (run_length),
	.final_run  (final_run)
);

`default_nettype wire

/* verif/tb_raster_rle_byte_decoder_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_raster_rle_byte_decoder_top
// Self-checking bench for the raster RLE byte decoder. Code bytes go in over a
// valid/ready channel with random gaps; each accepted byte runs through a
// decoder model that queues the run it should produce, and every run taken
// from the output is compared field by field with the oldest queued run.
// ----------------------------------------------------------------------------

module tb_raster_rle_byte_decoder_top;

	import rrle_pkg::*;

	localparam int CLK_HALF     = 4;
	localparam int ITEMS_RANDOM = 1850;
	localparam int SETTLE       = 6;

	typedef enum logic [1:0] {
		ESC_NONE,
		ESC_SEEN,
		ESC_COUNT
	} esc_phase_t;

	// Decoder model plus the queue of runs still owed by the block
	class run_ledger;
		logic [31:0] total_cfg;
		logic [31:0] budget_cfg;
		logic [31:0] left_out;
		logic [31:0] left_in;
		logic [7:0]  count_byte;
		esc_phase_t  phase;
		bit          done;
		int          n_errors;
		rrle_run_t   runs_due [$];

		function new();
			total_cfg  = TOTAL_RESET;
			budget_cfg = BUDGET_RESET;
			n_errors   = 0;
			restart();
		endfunction

		function void restart();
			phase      = ESC_NONE;
			count_byte = '0;
			left_out   = total_cfg;
			left_in    = (budget_cfg != 0) ? budget_cfg : total_cfg;
			done       = 1'b0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
			if (idx == REG_TOTAL_BYTES) begin
				total_cfg = data;
			end else begin
				budget_cfg = data;
			end
			restart();
		endfunction

		function void push_run(logic [7:0] value, logic [31:0] length);
			rrle_run_t r;
			r.value  = value;
			r.length = length[8:0];
			left_out = left_out - length;
			r.last   = (left_out == 0) || (left_in == 0);
			if (r.last) begin
				done = 1'b1;
			end
			runs_due.push_back(r);
		endfunction

		// Returns 0 when the byte is dropped because decoding already ended
		function bit take_byte(logic [7:0] b);
			logic [31:0] extra;
			if (done) begin
				return 1'b0;
			end
			case (phase)
				ESC_SEEN: begin
					if (left_in != 0) begin
						left_in = left_in - 1;
					end
					if (b == 8'd0) begin
						phase = ESC_NONE;
						push_run(ESCAPE_CODE, 32'd1);
					end else begin
						count_byte = b;
						phase      = ESC_COUNT;
					end
				end
				ESC_COUNT: begin
					if (left_in != 0) begin
						left_in = left_in - 1;
					end
					phase = ESC_NONE;
					extra = {24'd0, count_byte};
					// the symbol itself already owns one output byte
					if (extra > left_out - 1) begin
						extra = left_out - 1;
					end
					push_run(b, extra + 1);
				end
				default: begin
					phase = ESC_NONE;
					if (left_out == 0 || left_in == 0) begin
						done = 1'b1;
					end else begin
						left_in = left_in - 1;
						if (b == ESCAPE_CODE) begin
							phase = ESC_SEEN;
						end else begin
							push_run(b, 32'd1);
						end
					end
				end
			endcase
			return 1'b1;
		endfunction

		task flag(string what);
			n_errors++;
			$display("MISMATCH at %0t: %s", $realtime, what);
		endtask

		task match_run(logic [7:0] v, logic [8:0] len, logic fin);
			rrle_run_t e;
			if (runs_due.size() == 0) begin
				flag($sformatf("unexpected run value=%0d length=%0d final=%0b", v, len, fin));
				return;
			end
			e = runs_due.pop_front();
			if (v !== e.value) begin
				flag($sformatf("run_value %0d, want %0d", v, e.value));
			end
			if (len !== e.length) begin
				flag($sformatf("run_length %0d, want %0d", len, e.length));
			end
			if (fin !== e.last) begin
				flag($sformatf("final_run %0b, want %0b", fin, e.last));
			end
		endtask
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic [7:0]           code_byte;
	logic                 out_valid;
	logic                 out_ready;
	logic [7:0]           run_value;
	logic [8:0]           run_length;
	logic                 final_run;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [31:0]          cfg_wdata;

	run_ledger ledger;
	int        in_gap_pct    = 10;
	int        out_stall_pct = 58;
	int        n_live;

	raster_rle_byte_decoder_top i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.code_byte  (code_byte),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.run_value  (run_value),
		.run_length (run_length),
		.final_run  (final_run),
		.cfg_we     (cfg_we),
		.cfg_idx    (cfg_idx),
		.cfg_wdata  (cfg_wdata)
	);

	always #CLK_HALF clk = ~clk;

	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= out_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			ledger.match_run(run_value, run_length, final_run);
		end
	end

	// Called and returns at a falling edge
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < in_gap_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid  <= 1'b1;
		code_byte <= b;
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
		n_live += ledger.take_byte(b);
		@(negedge clk);
	endtask

	task automatic send_seq(input logic [7:0] list [$]);
		foreach (list[k]) begin
			send_byte(list[k]);
		end
	endtask

	// Leaves the write enable high; the caller lowers it
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		ledger.set_reg(idx, data);
		@(negedge clk);
	endtask

	task automatic configure(input logic [31:0] total, input logic [31:0] budget);
		if ($urandom_range(1) == 0) begin
			write_reg(REG_TOTAL_BYTES, total);
			write_reg(REG_INPUT_BUDGET, budget);
		end else begin
			write_reg(REG_INPUT_BUDGET, budget);
			write_reg(REG_TOTAL_BYTES, total);
		end
		cfg_we <= 1'b0;
	endtask

	// Wait out owed runs, then let bytes that yield no run clear the pipe
	task automatic drain_out();
		in_valid <= 1'b0;
		while (ledger.runs_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic send_symbol();
		int         pick;
		logic [7:0] b;
		pick = $urandom_range(99);
		if (pick < 45) begin
			b = 8'($urandom_range(254));
			if (b >= ESCAPE_CODE) begin
				b = b + 8'd1;
			end
			send_byte(b);
		end else if (pick < 55) begin
			send_byte(ESCAPE_CODE);
			send_byte(8'd0);
		end else if (pick < 85) begin
			send_byte(ESCAPE_CODE);
			send_byte(($urandom_range(3) == 0) ? 8'hFF : 8'($urandom_range(255, 1)));
			send_byte(8'($urandom_range(255)));
		end else begin
			// stray byte: may open an escape or break one
			send_byte(8'($urandom_range(255)));
		end
	endtask

	task automatic random_phase();
		int          n_sym;
		logic [31:0] total;
		logic [31:0] budget;
		case ($urandom_range(9))
			0: begin
				total  = $urandom_range(60, 1);
				budget = '0;
			end
			1: begin
				total  = $urandom_range(80, 1);
				budget = $urandom_range(40, 1);
			end
			2: begin
				total  = $urandom;
				budget = '0;
			end
			3: begin
				total  = '1;
				budget = '1;
			end
			4: begin
				total  = $urandom;
				budget = $urandom_range(30, 1);
			end
			5: begin
				total  = $urandom_range(3000, 200);
				budget = $urandom;
			end
			default: begin
				total  = $urandom_range(3000, 200);
				budget = '0;
			end
		endcase
		configure(total, budget);
		n_sym = $urandom_range(60, 10);
		for (int k = 0; k < n_sym && !ledger.done; k++) begin
			send_symbol();
		end
		repeat ($urandom_range(2)) send_byte(8'($urandom_range(255)));
		drain_out();
	endtask

	initial begin
		logic [7:0] seq [$];
		ledger    = new();
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		code_byte = '0;
		out_ready = 1'b0;
		cfg_we    = 1'b0;
		cfg_idx   = '0;
		cfg_wdata = '0;
		n_live    = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset settings: budget of one byte runs out inside the escape
		seq = '{ESCAPE_CODE, 8'd5, 8'h3C, 8'hFF};
		send_seq(seq);
		drain_out();

		// Plain extremes, escaped 128, longest run, then a clamped run
		configure(32'd300, 32'd0);
		seq = '{8'h00, 8'hFF, 8'h7F, 8'h81, ESCAPE_CODE, 8'd0,
			ESCAPE_CODE, 8'd255, 8'hA5, ESCAPE_CODE, 8'd1, 8'h5A,
			ESCAPE_CODE, 8'd128, ESCAPE_CODE};
		send_seq(seq);
		drain_out();

		// Nothing expected: first byte ends decoding silently
		configure(32'd0, 32'd4);
		seq = '{8'h55, 8'h01};
		send_seq(seq);
		drain_out();

		// Budget exhausted in the middle of an escape
		configure(32'd1000, 32'd2);
		seq = '{ESCAPE_CODE, 8'd3, 8'h77};
		send_seq(seq);
		drain_out();

		configure('1, '1);
		seq = '{ESCAPE_CODE, 8'd255, 8'h00};
		send_seq(seq);
		drain_out();

		n_live = 0;
		while (n_live < ITEMS_RANDOM) begin
			if (n_live < ITEMS_RANDOM / 3) begin
				in_gap_pct    = 10;
				out_stall_pct = 58;
			end else if (n_live < 2 * ITEMS_RANDOM / 3) begin
				in_gap_pct    = 58;
				out_stall_pct = 10;
			end else begin
				in_gap_pct    = 0;
				out_stall_pct = 0;
			end
			random_phase();
		end

		if (ledger.n_errors == 0 && ledger.runs_due.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule
